/* sv/ppmp_pkg.sv */
package ppmp_pkg;

   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_HASH    = 8'h23;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   localparam logic [2:0] KIND_FORMAT = 3'd0;
   localparam logic [2:0] KIND_WIDTH  = 3'd1;
   localparam logic [2:0] KIND_HEIGHT = 3'd2;
   localparam logic [2:0] KIND_MAXC   = 3'd3;
   localparam logic [2:0] KIND_SAMPLE = 3'd4;

   localparam logic [1:0] CHANNEL_BLUE = 2'd2;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       eof;
      logic       sep;
      logic       digit;
      logic       hash;
      logic       newline;
   } token_byte_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] value;
      logic [1:0]  channel;
      logic [15:0] column;
      logic [15:0] row;
      logic        last;
   } result_type;

endpackage

/* sv/ppmp_req_if.sv */
interface ppmp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       end_of_file;

   modport source (output valid, output byte_in, output end_of_file, input ready);
   modport sink (input valid, input byte_in, input end_of_file, output ready);
endinterface

/* sv/ppmp_rsp_if.sv */
interface ppmp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [15:0] value;
   logic [1:0]  channel;
   logic [15:0] column;
   logic [15:0] row;
   logic        last;

   modport source (output valid, output kind, output value, output channel,
                   output column, output row, output last, input ready);
   modport sink (input valid, input kind, input value, input channel,
                 input column, input row, input last, output ready);
endinterface

/* sv/ppmp_front.sv */
module ppmp_front (
   input  logic                    clock,
   input  logic                    reset,
   ppmp_req_if.sink                req_bus,
   output logic                    q_valid,
   output ppmp_pkg::token_byte_type q_entry,
   input  logic                    q_pop
);

   ppmp_pkg::token_byte_type entry_ff [2];
   ppmp_pkg::token_byte_type class_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   // byte classification
   always_comb begin
      class_in.byte_in = req_bus.byte_in;
      class_in.eof     = req_bus.end_of_file;
      class_in.newline = (req_bus.byte_in == ppmp_pkg::CHAR_NEWLINE);
      class_in.sep     = req_bus.end_of_file || class_in.newline
                         || (req_bus.byte_in == ppmp_pkg::CHAR_SPACE)
                         || (req_bus.byte_in == ppmp_pkg::CHAR_TAB);
      class_in.digit   = (req_bus.byte_in >= ppmp_pkg::CHAR_ZERO)
                         && (req_bus.byte_in <= ppmp_pkg::CHAR_NINE);
      class_in.hash    = (req_bus.byte_in == ppmp_pkg::CHAR_HASH);
   end

   assign req_bus.ready = (count_ff != 2'd2);
   assign push          = req_bus.valid && req_bus.ready;
   assign q_valid       = (count_ff != 2'd0);
   assign pop           = q_pop && q_valid;
   assign q_entry       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= class_in;
      end
   end

endmodule

/* sv/ppmp_back.sv */
module ppmp_back #(
   parameter int VALUE_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  ppmp_pkg::token_byte_type q_entry,
   output logic                     q_pop,
   ppmp_rsp_if.source               rsp_bus
);

   localparam logic [2:0] PH_MAGIC1 = 3'd0;
   localparam logic [2:0] PH_MAGIC2 = 3'd1;
   localparam logic [2:0] PH_WIDTH  = 3'd2;
   localparam logic [2:0] PH_HEIGHT = 3'd3;
   localparam logic [2:0] PH_MAXC   = 3'd4;
   localparam logic [2:0] PH_SAMPLE = 3'd5;
   localparam logic [2:0] PH_DONE   = 3'd6;

   localparam int WIDE_BITS = VALUE_BITS + 4;
   localparam logic [WIDE_BITS-1:0] MAX_WIDE = {4'd0, {VALUE_BITS{1'b1}}};

   logic [2:0]            phase_ff, phase_in;
   logic                  in_comment_ff, in_comment_in;
   logic                  in_token_ff, in_token_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [7:0]            magic_ff, magic_in;
   logic [15:0]           width_ff, width_in;
   logic [15:0]           height_ff, height_in;
   logic [1:0]            chan_ff, chan_in;
   logic [15:0]           col_ff, col_in;
   logic [15:0]           row_ff, row_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   ppmp_pkg::result_type  rsp_ff, rsp_in;

   logic                  load;
   logic [WIDE_BITS-1:0]  acc_next;
   logic [31:0]           acc_wide;
   logic [15:0]           acc_sat;
   logic                  col_end;
   logic                  row_end;
   logic                  last_sample;

   assign q_pop    = q_valid && (!rsp_valid_ff || rsp_bus.ready);
   assign acc_next = ({4'd0, acc_ff} << 3) + ({4'd0, acc_ff} << 1)
                     + WIDE_BITS'(q_entry.byte_in[3:0]);
   assign acc_wide = 32'(acc_ff);
   assign acc_sat  = (acc_wide > 32'h0000_FFFF) ? 16'hFFFF : acc_wide[15:0];
   assign col_end  = ({1'b0, col_ff} + 17'd1) >= {1'b0, width_ff};
   assign row_end  = ({1'b0, row_ff} + 17'd1) >= {1'b0, height_ff};
   assign last_sample = (chan_ff == ppmp_pkg::CHANNEL_BLUE) && col_end && row_end;

   always_comb begin
      phase_in      = phase_ff;
      in_comment_in = in_comment_ff;
      in_token_in   = in_token_ff;
      acc_in        = acc_ff;
      magic_in      = magic_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      chan_in       = chan_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      load          = 1'b0;
      rsp_in        = rsp_ff;
      if (q_pop) begin
         case (phase_ff)
            PH_MAGIC1: begin
               if (!q_entry.eof) begin
                  magic_in = q_entry.byte_in;
                  phase_in = PH_MAGIC2;
               end
            end
            PH_MAGIC2: begin
               if (!q_entry.eof) begin
                  phase_in = PH_WIDTH;
                  load     = 1'b1;
                  rsp_in   = '{ppmp_pkg::KIND_FORMAT, {magic_ff, q_entry.byte_in},
                               2'd0, 16'd0, 16'd0, 1'b0};
               end
            end
            PH_WIDTH, PH_HEIGHT, PH_MAXC, PH_SAMPLE: begin
               if (in_comment_ff) begin
                  if (q_entry.eof || q_entry.newline) begin
                     in_comment_in = 1'b0;
                  end
               end else if (q_entry.sep) begin
                  if (in_token_ff) begin
                     acc_in      = '0;
                     in_token_in = 1'b0;
                     load        = 1'b1;
                     rsp_in      = '{ppmp_pkg::KIND_WIDTH, acc_wide[15:0],
                                    2'd0, 16'd0, 16'd0, 1'b0};
                     case (phase_ff)
                        PH_WIDTH: begin
                           width_in = acc_sat;
                           phase_in = PH_HEIGHT;
                        end
                        PH_HEIGHT: begin
                           height_in   = acc_sat;
                           phase_in    = PH_MAXC;
                           rsp_in.kind = ppmp_pkg::KIND_HEIGHT;
                        end
                        PH_MAXC: begin
                           chan_in     = 2'd0;
                           col_in      = 16'd0;
                           row_in      = 16'd0;
                           rsp_in.kind = ppmp_pkg::KIND_MAXC;
                           phase_in    = (width_ff == 16'd0 || height_ff == 16'd0)
                                         ? PH_DONE : PH_SAMPLE;
                        end
                        default: begin
                           rsp_in = '{ppmp_pkg::KIND_SAMPLE, acc_wide[15:0],
                                      chan_ff, col_ff, row_ff, last_sample};
                           if (chan_ff == ppmp_pkg::CHANNEL_BLUE) begin
                              chan_in = 2'd0;
                              if (col_end) begin
                                 col_in = 16'd0;
                                 row_in = row_ff + 16'd1;
                              end else begin
                                 col_in = col_ff + 16'd1;
                              end
                           end else begin
                              chan_in = chan_ff + 2'd1;
                           end
                           if (last_sample) begin
                              phase_in = PH_DONE;
                           end
                        end
                     endcase
                  end
               end else if (q_entry.digit) begin
                  acc_in      = (acc_next > MAX_WIDE) ? {VALUE_BITS{1'b1}}
                                                      : acc_next[VALUE_BITS-1:0];
                  in_token_in = 1'b1;
               end else if (!in_token_ff && q_entry.hash) begin
                  in_comment_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      rsp_valid_in = load || (rsp_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_MAGIC1;
         in_comment_ff <= 1'b0;
         in_token_ff   <= 1'b0;
         acc_ff        <= '0;
         magic_ff      <= 8'd0;
         width_ff      <= 16'd0;
         height_ff     <= 16'd0;
         chan_ff       <= 2'd0;
         col_ff        <= 16'd0;
         row_ff        <= 16'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         in_comment_ff <= in_comment_in;
         in_token_ff   <= in_token_in;
         acc_ff        <= acc_in;
         magic_ff      <= magic_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         chan_ff       <= chan_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.kind    = rsp_ff.kind;
   assign rsp_bus.value   = rsp_ff.value;
   assign rsp_bus.channel = rsp_ff.channel;
   assign rsp_bus.column  = rsp_ff.column;
   assign rsp_bus.row     = rsp_ff.row;
   assign rsp_bus.last    = rsp_ff.last;

endmodule

/* sv/ascii_ppm_stream_parser.sv */
// channel   dir   handshake     payload
// req_bus   in    valid/ready   byte_in[7:0], end_of_file
// rsp_bus   out   valid/ready   kind[2:0], value[15:0], channel[1:0], column[15:0],
//                               row[15:0], last
//
// one byte per cycle sustained while results are taken; a byte is classified into a
// two-entry queue at its transfer and updates the parser state when the queue pops it,
// loading any result then; results sit in one output register; the parser holds the
// next byte while it waits; req_bus.ready drops only when the queue holds two bytes
// synchronous reset returns the parser to the first magic byte
module ascii_ppm_stream_parser #(
   parameter int VALUE_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   ppmp_req_if.sink   req_bus,
   ppmp_rsp_if.source rsp_bus
);

   logic                     q_valid;
   logic                     q_pop;
   ppmp_pkg::token_byte_type q_entry;

   ppmp_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_valid (q_valid),
      .q_entry (q_entry),
      .q_pop   (q_pop)
   );

   ppmp_back #(
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_entry (q_entry),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

endmodule
